### hdl/grr_pkg.sv
`default_nettype none

package grr_pkg;

  // request types on the input channel
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_PRINT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WIN  = 2'd0;
  localparam logic [1:0] KIND_ROW  = 2'd1;
  localparam logic [1:0] KIND_CLIP = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_GLYPH_W  = 3'd0;
  localparam logic [2:0] CFG_GLYPH_H  = 3'd1;
  localparam logic [2:0] CFG_CELL_W   = 3'd2;
  localparam logic [2:0] CFG_CELL_H   = 3'd3;
  localparam logic [2:0] CFG_PROP     = 3'd4;
  localparam logic [2:0] CFG_SCREEN_W = 3'd5;

  // replacement for codes outside the font
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  // glyph base address width: 8-bit index times 5-bit height
  localparam int BASE_W = 13;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] font_addr;
    logic [7:0]  font_byte;
    logic [15:0] start_left;
    logic [15:0] start_top;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] win_left;
    logic [15:0] win_top;
    logic [4:0]  win_width;
    logic [4:0]  win_height;
    logic [15:0] row_mask;
    logic [4:0]  advance;
    logic [15:0] total_width;
    logic        last;
  } out_item_t;

  // saturated configuration seen by front and back
  typedef struct packed {
    logic [3:0]  gw;
    logic [4:0]  gh;
    logic [4:0]  cw;
    logic [4:0]  ch;
    logic [4:0]  pad;
    logic        prop;
    logic [15:0] screen_width;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PRINT = 2'd2
  } op_t;

  // one classified item in the queue
  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] addr;
    logic [7:0]        font_byte;
    logic [7:0]        idx;
    logic [15:0]       left;
    logic [15:0]       top;
  } q_entry_t;

endpackage

`default_nettype wire

### hdl/grr_front.sv
`default_nettype none

module grr_front #(
  parameter int FIRST_CODE = 32,
  parameter int LAST_CODE  = 127
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  grr_pkg::cfg_t       cfg,
  input  wire                 in_valid,
  output logic                in_stall,
  input  grr_pkg::in_item_t   in_data,
  input  wire                 q_full,
  output logic                q_push,
  output grr_pkg::q_entry_t   q_entry
);
  import grr_pkg::*;

  logic [7:0] code;
  logic [7:0] idx;
  logic       accept;

  // stall only while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // map out-of-range codes to the replacement glyph
  always_comb begin
    code = in_data.char_code;
    if ((32'(in_data.char_code) < FIRST_CODE) || (32'(in_data.char_code) > LAST_CODE)) begin
      code = CHAR_QMARK;
    end
    idx = code - 8'(FIRST_CODE);
  end

  // classify the item and build the queue entry
  always_comb begin
    q_entry           = '0;
    q_entry.font_byte = in_data.font_byte;
    q_entry.idx       = idx;
    q_entry.left      = in_data.start_left;
    q_entry.top       = in_data.start_top;
    q_push            = 1'b0;
    unique case (in_data.req_type)
      REQ_LOAD: begin
        q_entry.op   = OP_LOAD;
        q_entry.addr = BASE_W'(in_data.font_addr);
        q_push       = accept;
      end
      REQ_START: begin
        q_entry.op = OP_START;
        q_push     = accept;
      end
      REQ_PRINT: begin
        q_entry.op   = OP_PRINT;
        q_entry.addr = idx * cfg.gh;
        q_push       = accept;
      end
      default: begin
        // unused request type: taken and dropped
        q_entry.op = OP_START;
        q_push     = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/grr_queue.sv
`default_nettype none

module grr_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  grr_pkg::q_entry_t  push_entry,
  output logic               full,
  input  wire                pop,
  output logic               valid,
  output grr_pkg::q_entry_t  head
);
  import grr_pkg::*;

  q_entry_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) count_r <= count_r + 2'd1;
      else if (!do_push && do_pop) count_r <= count_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

### hdl/grr_back.sv
`default_nettype none

module grr_back #(
  parameter int FONT_BYTES = 2048
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  grr_pkg::cfg_t       cfg,
  input  wire                 q_valid,
  input  grr_pkg::q_entry_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output grr_pkg::out_item_t  out_data
);
  import grr_pkg::*;

  localparam int AW = $clog2(FONT_BYTES);
  localparam int QB = $clog2((1 << BASE_W) / FONT_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ROW  = 2'b10
  } state_t;

  // reduce an address modulo the font size by compare and subtract
  function automatic logic [AW-1:0] font_mod(input logic [BASE_W-1:0] a);
    logic [BASE_W-1:0] v;
    v = a;
    for (int k = QB - 1; k >= 0; k--) begin
      if ((FONT_BYTES << k) < (1 << BASE_W)) begin
        if (v >= BASE_W'(FONT_BYTES << k)) v = v - BASE_W'(FONT_BYTES << k);
      end
    end
    return AW'(v);
  endfunction

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == AW'(FONT_BYTES - 1)) ? '0 : a + 1'b1;
  endfunction

  logic [7:0]  font_mem [FONT_BYTES];
  logic [7:0]  rdata_r;

  state_t      state_r, state_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]  ormask_r, ormask_nxt;
  logic        idx_nz_r, idx_nz_nxt;
  logic [15:0] pen_left_r, pen_left_nxt;
  logic [15:0] pen_top_r, pen_top_nxt;
  logic [15:0] printed_r, printed_nxt;
  logic        stopped_r, stopped_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        out_free;
  logic        emit;
  out_item_t   item;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] base_mod;
  logic [4:0]  row_inc;
  logic        glyph_row;
  logic        fin;
  logic [7:0]  aligned;
  logic [7:0]  mask;
  logic [7:0]  or_all;
  logic [3:0]  tz;
  logic [4:0]  adv;
  logic [15:0] printed_sum;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign base_mod  = font_mod(q_head.addr);
  assign row_inc   = row_r + 5'd1;
  assign glyph_row = (row_r >= cfg.pad);
  assign fin       = (row_inc == cfg.ch);

  // font row to foreground mask, column 0 is the glyph's leftmost bit
  always_comb begin
    aligned = 8'(rdata_r << (4'd8 - cfg.gw));
    for (int c = 0; c < 8; c++) begin
      mask[c] = aligned[7 - c] && (4'(c) < cfg.gw) && (5'(c) < cfg.cw);
    end
  end

  // advance: cell width, or measured width in proportional mode for any glyph but index 0
  always_comb begin
    or_all = ormask_r | rdata_r;
    tz     = 4'd0;
    for (int k = 7; k >= 0; k--) begin
      if (or_all[k]) tz = 4'(k);
    end
    adv = cfg.cw;
    if (idx_nz_r && cfg.prop) begin
      if (or_all == 8'd0) adv = 5'd0;
      else if (cfg.cw > 5'(tz)) adv = cfg.cw - 5'(tz);
      else adv = 5'd0;
    end
    printed_sum = printed_r + 16'(adv);
  end

  // sequencer: one command or one row per cycle, prints and rows only while the output is free
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    addr_nxt     = addr_r;
    ormask_nxt   = ormask_r;
    idx_nz_nxt   = idx_nz_r;
    pen_left_nxt = pen_left_r;
    pen_top_nxt  = pen_top_r;
    printed_nxt  = printed_r;
    stopped_nxt  = stopped_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    item         = '0;
    rd_en        = 1'b0;
    rd_addr      = addr_r;
    wr_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.op)
            OP_LOAD: begin
              q_pop = 1'b1;
              wr_en = 1'b1;
            end
            OP_START: begin
              q_pop        = 1'b1;
              pen_left_nxt = q_head.left;
              pen_top_nxt  = q_head.top;
              printed_nxt  = 16'd0;
              stopped_nxt  = 1'b0;
            end
            OP_PRINT: begin
              if (stopped_r) begin
                q_pop = 1'b1;
              end else if (out_free) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                if (pen_left_r >= cfg.screen_width) begin
                  item.kind        = KIND_CLIP;
                  item.total_width = printed_r;
                  item.last        = 1'b1;
                  stopped_nxt      = 1'b1;
                end else begin
                  item.kind       = KIND_WIN;
                  item.win_left   = pen_left_r;
                  item.win_top    = pen_top_r;
                  item.win_width  = cfg.cw;
                  item.win_height = cfg.ch;
                  row_nxt         = 5'd0;
                  ormask_nxt      = 8'd0;
                  idx_nz_nxt      = (q_head.idx != 8'd0);
                  rd_addr         = base_mod;
                  addr_nxt        = base_mod;
                  if (cfg.pad == 5'd0) begin
                    rd_en    = 1'b1;
                    addr_nxt = addr_inc(base_mod);
                  end
                  state_nxt = ST_ROW;
                end
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_ROW: begin
        if (out_free) begin
          emit      = 1'b1;
          item.kind = KIND_ROW;
          if (glyph_row) begin
            item.row_mask = {8'd0, mask};
            ormask_nxt    = or_all;
          end
          if (fin) begin
            item.advance     = adv;
            item.total_width = printed_sum;
            item.last        = 1'b1;
            printed_nxt      = printed_sum;
            pen_left_nxt     = pen_left_r + 16'(adv);
            state_nxt        = ST_IDLE;
          end else begin
            row_nxt = row_inc;
            if (row_inc >= cfg.pad) begin
              rd_en    = 1'b1;
              addr_nxt = addr_inc(addr_r);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // font store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) font_mem[font_mod(q_head.addr)] <= q_head.font_byte;
    if (rd_en) rdata_r <= font_mem[rd_addr];
  end

  // control and pen state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pen_left_r  <= 16'd0;
      pen_top_r   <= 16'd0;
      printed_r   <= 16'd0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pen_left_r <= pen_left_nxt;
      pen_top_r  <= pen_top_nxt;
      printed_r  <= printed_nxt;
      stopped_r  <= stopped_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // per-character working registers and output item
  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    addr_r   <= addr_nxt;
    ormask_r <= ormask_nxt;
    idx_nz_r <= idx_nz_nxt;
    if (emit) out_r <= item;
  end

endmodule

`default_nettype wire

### hdl/glyph_row_rasterizer_top.sv
`default_nettype none

// Channel  Direction  Ports                          Item
// in       input      in_valid, in_stall, in_data    load / start / print request
// out      output     out_valid, out_stall, out_data window command, row mask, clip
// cfg      input      cfg_we, cfg_index, cfg_wdata   register write, no read-back
//
// Load and start items produce no output; a printed character gives a window
// command, then its cell-height rows, one row per cycle while the output is free,
// out of the single font memory read port. A clipped print gives a clip item.
// A two-entry queue lets input be taken while the back end is busy.
// Reset (rst_n low, synchronous) clears pen, width and stop state; the font
// store is not cleared. Output stall holds the current item and pauses rows.

module glyph_row_rasterizer_top #(
  parameter int FONT_BYTES = 2048,
  parameter int FIRST_CODE = 32,
  parameter int LAST_CODE  = 127,
  parameter int MAX_CELL   = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  grr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output grr_pkg::out_item_t  out_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [15:0]         cfg_wdata
);
  import grr_pkg::*;

  logic [3:0]  glyph_w_r;
  logic [4:0]  glyph_h_r;
  logic [4:0]  cell_w_r;
  logic [4:0]  cell_h_r;
  logic        prop_r;
  logic [15:0] screen_w_r;

  cfg_t        cfg;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  q_entry_t    q_entry;
  q_entry_t    q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_w_r  <= 4'd8;
      glyph_h_r  <= 5'd8;
      cell_w_r   <= 5'd8;
      cell_h_r   <= 5'd8;
      prop_r     <= 1'b0;
      screen_w_r <= 16'd320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLYPH_W:  glyph_w_r  <= cfg_wdata[3:0];
        CFG_GLYPH_H:  glyph_h_r  <= cfg_wdata[4:0];
        CFG_CELL_W:   cell_w_r   <= cfg_wdata[4:0];
        CFG_CELL_H:   cell_h_r   <= cfg_wdata[4:0];
        CFG_PROP:     prop_r     <= cfg_wdata[0];
        CFG_SCREEN_W: screen_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate the register values to their legal ranges
  always_comb begin
    cfg.gw = (glyph_w_r == 4'd0) ? 4'd1 : ((glyph_w_r > 4'd8) ? 4'd8 : glyph_w_r);
    cfg.gh = (glyph_h_r == 5'd0) ? 5'd1 :
             ((32'(glyph_h_r) > MAX_CELL) ? 5'(MAX_CELL) : glyph_h_r);
    cfg.cw = (cell_w_r == 5'd0) ? 5'd1 :
             ((32'(cell_w_r) > MAX_CELL) ? 5'(MAX_CELL) : cell_w_r);
    cfg.ch = (cell_h_r == 5'd0) ? 5'd1 :
             ((32'(cell_h_r) > MAX_CELL) ? 5'(MAX_CELL) : cell_h_r);
    cfg.pad          = (cfg.ch > cfg.gh) ? cfg.ch - cfg.gh : 5'd0;
    cfg.prop         = prop_r;
    cfg.screen_width = screen_w_r;
  end

  grr_front #(
    .FIRST_CODE (FIRST_CODE),
    .LAST_CODE  (LAST_CODE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  grr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  grr_back #(
    .FONT_BYTES (FONT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
